// File: src/tlux_pkg.sv
package tlux_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned POWER_TABLE_ENTRIES_DEF = 256;
  localparam int unsigned LUX_FRACTION_BITS_DEF   = 16;

  // Field widths
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned LUX_W   = 27;
  localparam int unsigned BAND_W  = 3;
  localparam int unsigned POW_W   = 16;
  localparam int unsigned COEF_W  = 28;
  localparam int unsigned PROD_W  = 44;

  // Ratio band edges, Q16
  localparam logic [RATIO_W-1:0] EDGE_050 = 17'd32768;
  localparam logic [RATIO_W-1:0] EDGE_061 = 17'd39977;
  localparam logic [RATIO_W-1:0] EDGE_080 = 17'd52429;
  localparam logic [RATIO_W-1:0] EDGE_130 = 17'd85197;

  // Formula coefficients, Q32
  localparam logic [COEF_W-1:0] C0304  = 28'd130567006;
  localparam logic [COEF_W-1:0] C062   = 28'd266287972;
  localparam logic [COEF_W-1:0] C0224  = 28'd96207267;
  localparam logic [COEF_W-1:0] C031   = 28'd133143986;
  localparam logic [COEF_W-1:0] C0128  = 28'd54975581;
  localparam logic [COEF_W-1:0] C0153  = 28'd65713000;
  localparam logic [COEF_W-1:0] C00146 = 28'd6270652;
  localparam logic [COEF_W-1:0] C00112 = 28'd4810363;

  localparam logic [LUX_W-1:0] LUX_MAX = 27'd134217727;

  // Band codes
  localparam logic [BAND_W-1:0] BAND_NONE = 3'd0;
  localparam logic [BAND_W-1:0] BAND_LOW  = 3'd1;
  localparam logic [BAND_W-1:0] BAND_MID1 = 3'd2;
  localparam logic [BAND_W-1:0] BAND_MID2 = 3'd3;
  localparam logic [BAND_W-1:0] BAND_HIGH = 3'd4;

  // Power table entry: largest p with p^5 * (4n)^7 <= (2k+1)^7 * 2^80
  function automatic logic [POW_W-1:0] power_entry(input int unsigned k,
                                                   input int unsigned n);
    logic [191:0] rhs;
    logic [191:0] lhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    rhs = 192'd1;
    for (int i = 0; i < 7; i++) rhs = rhs * 192'(2 * k + 1);
    rhs = rhs << 80;
    lo = 0;
    hi = 65535;
    for (int it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = 192'd1;
        for (int i = 0; i < 5; i++) lhs = lhs * 192'(mid);
        for (int i = 0; i < 7; i++) lhs = lhs * 192'(4 * n);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
    end
    return lo[POW_W-1:0];
  endfunction

endpackage

// File: src/two_channel_lux_calculation_unit.sv
// Two-channel lux calculation.
// Input channel: in_valid/in_ready with in_broadband_count and in_infrared_count,
// one request per reading. Result channel: out_valid/out_ready with
// out_lux_value (lux, LUX_FRACTION_BITS fraction bits, saturated to 27 bits)
// and out_ratio_band (0 = no band, 1..4 = band used).
// The pipeline has 21 register stages: 17 divider stages (one quotient bit
// each), a band/table stage, two multiplier stages and the output register.
// Throughput is one request per cycle while the output is not stalled.
// The whole pipeline advances together; when out_valid is high and out_ready
// is low, every stage holds and in_ready drops, so nothing is lost.
// Reset clears all stage valid bits; no table or memory needs clearing.
module two_channel_lux_calculation_unit import tlux_pkg::*; #(
  parameter int unsigned POWER_TABLE_ENTRIES = POWER_TABLE_ENTRIES_DEF,
  parameter int unsigned LUX_FRACTION_BITS   = LUX_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COUNT_W-1:0] in_broadband_count,
  input  logic [COUNT_W-1:0] in_infrared_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LUX_W-1:0]   out_lux_value,
  output logic [BAND_W-1:0]  out_ratio_band
);

  localparam int unsigned IDX_W = $clog2(POWER_TABLE_ENTRIES);
  localparam int unsigned KP_W  = RATIO_W + IDX_W + 1;
  localparam int unsigned SHIFT = 32 - LUX_FRACTION_BITS;

  logic en;

  logic               d_v;
  logic [COUNT_W-1:0] d_bb;
  logic [COUNT_W-1:0] d_ir;
  logic [RATIO_W-1:0] d_q;
  logic               d_ovf;

  logic               a_v_r;
  logic [BAND_W-1:0]  a_band_r;
  logic [COUNT_W-1:0] a_bb_r;
  logic [COUNT_W-1:0] a_ir_r;
  logic [POW_W-1:0]   a_p_r;

  logic               b_v_r;
  logic [BAND_W-1:0]  b_band_r;
  logic [PROD_W-1:0]  b_pos_r;
  logic [PROD_W-1:0]  b_t_r;

  logic               c_v_r;
  logic [BAND_W-1:0]  c_band_r;
  logic [PROD_W-1:0]  c_pos_r;
  logic [PROD_W-1:0]  c_neg_r;

  logic               out_valid_r;
  logic [LUX_W-1:0]   out_lux_r;
  logic [BAND_W-1:0]  out_band_r;

  logic [POW_W-1:0]   pow_tab [POWER_TABLE_ENTRIES];

  // Advance the whole pipeline unless the output is held
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  tlux_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_bb    (in_broadband_count),
    .in_ir    (in_infrared_count),
    .out_valid(d_v),
    .out_bb   (d_bb),
    .out_ir   (d_ir),
    .out_quot (d_q),
    .out_ovf  (d_ovf)
  );

  // Constant power table, ratio^1.4 at bin midpoints
  for (genvar gk = 0; gk < POWER_TABLE_ENTRIES; gk++) begin : g_tab
    localparam logic [POW_W-1:0] PVAL = power_entry(gk, POWER_TABLE_ENTRIES);
    assign pow_tab[gk] = PVAL;
  end

  // Stage A: pick band, look up power entry
  logic [BAND_W-1:0] a_band_nxt;
  logic [KP_W-1:0]   a_kprod;
  logic [KP_W-1:0]   a_kfull;
  logic [IDX_W-1:0]  a_k;

  always_comb begin
    priority if (d_ovf || d_q == '0) begin
      a_band_nxt = BAND_NONE;
    end else if (d_q <= EDGE_050) begin
      a_band_nxt = BAND_LOW;
    end else if (d_q <= EDGE_061) begin
      a_band_nxt = BAND_MID1;
    end else if (d_q <= EDGE_080) begin
      a_band_nxt = BAND_MID2;
    end else if (d_q <= EDGE_130) begin
      a_band_nxt = BAND_HIGH;
    end else begin
      a_band_nxt = BAND_NONE;
    end
    a_kprod = KP_W'(d_q) * KP_W'(POWER_TABLE_ENTRIES);
    a_kfull = a_kprod >> 15;
    if (a_kfull > KP_W'(POWER_TABLE_ENTRIES - 1)) begin
      a_k = IDX_W'(POWER_TABLE_ENTRIES - 1);
    end else begin
      a_k = a_kfull[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_band_r <= a_band_nxt;
      a_bb_r   <= d_bb;
      a_ir_r   <= d_ir;
      a_p_r    <= pow_tab[a_k];
    end
  end

  // Stage B: positive term, and the negative term (low band: its first factor only)
  logic [COEF_W-1:0] b_ca;
  logic [COEF_W-1:0] b_cb;

  always_comb begin
    unique case (a_band_r)
      BAND_LOW: begin
        b_ca = C0304;
        b_cb = C062;
      end
      BAND_MID1: begin
        b_ca = C0224;
        b_cb = C031;
      end
      BAND_MID2: begin
        b_ca = C0128;
        b_cb = C0153;
      end
      BAND_HIGH: begin
        b_ca = C00146;
        b_cb = C00112;
      end
      default: begin
        b_ca = '0;
        b_cb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_band_r <= a_band_r;
      b_pos_r  <= PROD_W'(a_bb_r) * PROD_W'(b_ca);
      if (a_band_r == BAND_LOW) begin
        b_t_r <= PROD_W'(a_bb_r) * PROD_W'(a_p_r);
      end else begin
        b_t_r <= PROD_W'(a_ir_r) * PROD_W'(b_cb);
      end
    end
  end

  // Stage C: finish the low-band negative term
  logic [PROD_W+16-1:0] c_lowprod;

  assign c_lowprod = (PROD_W + 16)'(b_t_r[31:0]) * (PROD_W + 16)'(C062);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_band_r <= b_band_r;
      c_pos_r  <= b_pos_r;
      if (b_band_r == BAND_LOW) begin
        c_neg_r <= c_lowprod[PROD_W+16-1:16];
      end else begin
        c_neg_r <= b_t_r;
      end
    end
  end

  // Output stage: subtract, clamp at zero, scale, saturate
  logic [PROD_W-1:0] o_diff;
  logic [PROD_W-1:0] o_scaled;
  logic [LUX_W-1:0]  o_lux;

  always_comb begin
    o_diff   = c_pos_r - c_neg_r;
    o_scaled = o_diff >> SHIFT;
    if (c_band_r == BAND_NONE || c_pos_r <= c_neg_r) begin
      o_lux = '0;
    end else if (o_scaled > PROD_W'(LUX_MAX)) begin
      o_lux = LUX_MAX;
    end else begin
      o_lux = o_scaled[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lux_r  <= o_lux;
      out_band_r <= c_band_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lux_value  = out_lux_r;
  assign out_ratio_band = out_band_r;

  // No band means no light reported
  a_band0_lux0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_band_r == BAND_NONE |-> out_lux_r == '0)
    else $error("lux nonzero without a band");

  // Band code stays within the defined range
  a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_band_r <= BAND_HIGH)
    else $error("band code out of range");

  // Stage C valid and positive term hold while the output is stalled
  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(c_v_r) && $stable(c_pos_r))
    else $error("pipeline moved during stall");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("output valid right after reset");

endmodule

// File: src/tlux_div.sv
module tlux_div import tlux_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [COUNT_W-1:0] in_bb,
  input  logic [COUNT_W-1:0] in_ir,
  output logic               out_valid,
  output logic [COUNT_W-1:0] out_bb,
  output logic [COUNT_W-1:0] out_ir,
  output logic [RATIO_W-1:0] out_quot,
  output logic               out_ovf
);

  logic               v_r   [RATIO_W];
  logic               ovf_r [RATIO_W];
  logic [COUNT_W-1:0] bb_r  [RATIO_W];
  logic [COUNT_W-1:0] ir_r  [RATIO_W];
  logic [COUNT_W-1:0] rem_r [RATIO_W];
  logic [RATIO_W-1:0] q_r   [RATIO_W];

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < RATIO_W; j++) begin : g_stage
    logic               v_in;
    logic               ovf_in;
    logic [COUNT_W-1:0] bb_in;
    logic [COUNT_W-1:0] ir_in;
    logic [COUNT_W-1:0] rem_in;
    logic [RATIO_W-1:0] q_in;
    logic               dbit;
    logic [COUNT_W:0]   trial;
    logic               ge;
    logic [COUNT_W-1:0] rem_nxt;
    logic [RATIO_W-1:0] q_nxt;

    if (j == 0) begin : g_first
      // Quotient fits 17 bits only when ir < 2*bb; this also flags bb == 0
      assign v_in   = in_valid;
      assign bb_in  = in_bb;
      assign ir_in  = in_ir;
      assign rem_in = {1'b0, in_ir[COUNT_W-1:1]};
      assign q_in   = '0;
      assign ovf_in = ({1'b0, in_ir} >= {in_bb, 1'b0});
      assign dbit   = in_ir[0];
    end else begin : g_next
      assign v_in   = v_r[j-1];
      assign bb_in  = bb_r[j-1];
      assign ir_in  = ir_r[j-1];
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign ovf_in = ovf_r[j-1];
      assign dbit   = 1'b0;
    end

    // Trial subtract
    always_comb begin
      trial   = {rem_in, dbit};
      ge      = (trial >= {1'b0, bb_in});
      rem_nxt = ge ? COUNT_W'(trial - {1'b0, bb_in}) : trial[COUNT_W-1:0];
      q_nxt   = q_in;
      q_nxt[RATIO_W-1-j] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[j] <= ovf_in;
        bb_r[j]  <= bb_in;
        ir_r[j]  <= ir_in;
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
      end
    end
  end

  assign out_valid = v_r[RATIO_W-1];
  assign out_bb    = bb_r[RATIO_W-1];
  assign out_ir    = ir_r[RATIO_W-1];
  assign out_quot  = q_r[RATIO_W-1];
  assign out_ovf   = ovf_r[RATIO_W-1];

endmodule

// File: dv/lux_checker.sv
`timescale 1ns / 1ps

module lux_checker import tlux_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [COUNT_W-1:0] in_broadband_count,
  input  logic [COUNT_W-1:0] in_infrared_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LUX_W-1:0]   out_lux_value,
  input  logic [BAND_W-1:0]  out_ratio_band,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int unsigned N_POW = POWER_TABLE_ENTRIES_DEF;
  localparam int unsigned FRAC  = LUX_FRACTION_BITS_DEF;

  typedef struct packed {
    logic [LUX_W-1:0]  lux;
    logic [BAND_W-1:0] band;
  } lux_reading_t;

  lux_reading_t    lux_queue[$];
  logic [POW_W-1:0] pow14_table [N_POW];

  // Exact test: p^5 * (4N)^7 <= (2k+1)^7 * 2^80
  function automatic bit pow_fits(input longint unsigned p, input int unsigned k);
    logic [191:0] lhs;
    logic [191:0] rhs;
    lhs = 192'd1;
    rhs = 192'd1;
    for (int i = 0; i < 5; i++) lhs = lhs * 192'(p);
    for (int i = 0; i < 7; i++) lhs = lhs * 192'(4 * N_POW);
    for (int i = 0; i < 7; i++) rhs = rhs * 192'(2 * k + 1);
    rhs = rhs << 80;
    return lhs <= rhs;
  endfunction

  // Seed each entry from floating point, then settle it exactly
  initial begin
    longint unsigned p;
    for (int k = 0; k < N_POW; k++) begin
      p = longint'($floor($pow((2.0 * k + 1.0) / (4.0 * N_POW), 1.4) * 65536.0));
      while (p < 65535 && pow_fits(p + 1, k)) p++;
      while (p > 0 && !pow_fits(p, k)) p--;
      pow14_table[k] = p[POW_W-1:0];
    end
  end

  function automatic lux_reading_t calc_lux(input logic [COUNT_W-1:0] bb,
                                            input logic [COUNT_W-1:0] ir);
    lux_reading_t    res;
    longint unsigned r, k, pos, neg, l;
    res = '0;
    if (bb == 0) return res;
    r = (longint'(ir) << 16) / bb;
    if (r == 0 || r > EDGE_130) return res;
    if (r <= EDGE_050) begin
      k = (r * N_POW) >> 15;
      if (k > N_POW - 1) k = N_POW - 1;
      pos = longint'(bb) * C0304;
      neg = (longint'(bb) * C062 * pow14_table[k]) >> 16;
      res.band = BAND_LOW;
    end else if (r <= EDGE_061) begin
      pos = longint'(bb) * C0224;
      neg = longint'(ir) * C031;
      res.band = BAND_MID1;
    end else if (r <= EDGE_080) begin
      pos = longint'(bb) * C0128;
      neg = longint'(ir) * C0153;
      res.band = BAND_MID2;
    end else begin
      pos = longint'(bb) * C00146;
      neg = longint'(ir) * C00112;
      res.band = BAND_HIGH;
    end
    l = (pos > neg) ? ((pos - neg) >> (32 - FRAC)) : 0;
    if (l > LUX_MAX) l = LUX_MAX;
    res.lux = l[LUX_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending_count = 0;

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    lux_reading_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        lux_queue.push_back(calc_lux(in_broadband_count, in_infrared_count));
      if (out_valid && out_ready) begin
        if (lux_queue.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = lux_queue.pop_front();
          if (out_lux_value !== want.lux)
            report_mismatch($sformatf("lux %0d, want %0d", out_lux_value, want.lux));
          if (out_ratio_band !== want.band)
            report_mismatch($sformatf("band %0d, want %0d", out_ratio_band, want.band));
        end
      end
    end
    pending_count = lux_queue.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tlux_pkg::*;

  localparam int N_RANDOM    = 1730;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [COUNT_W-1:0] in_broadband_count;
  logic [COUNT_W-1:0] in_infrared_count;
  logic               out_valid;
  logic               out_ready;
  logic [LUX_W-1:0]   out_lux_value;
  logic [BAND_W-1:0]  out_ratio_band;
  int                 fail_count;
  int                 pending_count;
  int                 sent_count;
  int                 cycle_count;
  bit                 steady;

  two_channel_lux_calculation_unit i_dut (.*);

  lux_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_broadband_count = '0;
    in_infrared_count = '0;
    out_ready = 1'b0;
    sent_count = 0;
    steady = 1'b0;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Drain results; stall at random, and once hold off long enough to fill the pipe
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && sent_count >= 500) begin
        hold = 400;
        held = 1'b1;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 15);
      end
      @(posedge clk);
    end
  end

  // Offer one request, idle first at random, hold until accepted
  task automatic send_reading(input logic [COUNT_W-1:0] bb, input logic [COUNT_W-1:0] ir);
    while (!steady && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_broadband_count <= bb;
    in_infrared_count <= ir;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    logic [COUNT_W-1:0] bb;
    logic [COUNT_W-1:0] ir;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero counts, extremes, band edges, out of range
    send_reading(16'd0, 16'd0);
    send_reading(16'd0, 16'hFFFF);
    send_reading(16'hFFFF, 16'd0);
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'd1, 16'd1);
    send_reading(16'd2, 16'd1);
    send_reading(16'd65535, 16'd1);
    send_reading(16'd65535, 16'd32767);
    send_reading(16'd65535, 16'd32768);
    send_reading(16'd65535, 16'd39976);
    send_reading(16'd65535, 16'd39977);
    send_reading(16'd65535, 16'd52428);
    send_reading(16'd65535, 16'd52430);
    send_reading(16'd50000, 16'd65000);
    send_reading(16'd50000, 16'd65001);
    send_reading(16'd100, 16'd200);
    send_reading(16'd10000, 16'd5500);
    send_reading(16'd10000, 16'd7000);
    send_reading(16'd10000, 16'd10000);
    send_reading(16'hAAAA, 16'h5555);
    send_reading(16'h5555, 16'h2AAA);

    // Random: mostly in-band ratios, some raw values and small counts
    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 900 && i < 1150);
      bb = COUNT_W'($urandom());
      case ($urandom_range(0, 9))
        0, 1: ir = COUNT_W'($urandom());
        2: begin
          bb = COUNT_W'($urandom_range(0, 15));
          ir = COUNT_W'($urandom_range(0, 20));
        end
        default: ir = 16'((longint'(bb) * $urandom_range(0, 88000)) >> 16);
      endcase
      send_reading(bb, ir);
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // Drain, then let the pipeline settle
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
